/* sv/char_lcd_cursor_sequencer_defines.svh */
// Assertion macros shared by the character display sequencer.
`ifndef CHAR_LCD_CURSOR_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_CURSOR_SEQUENCER_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define LCDCS_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define LCDCS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

/* sv/lcdcs_pkg.sv */
// Package: types, codes and constants of the character display sequencer.
package lcdcs_pkg;

  localparam int DefColumns = 20;
  localparam int DefRows    = 4;
  localparam int ColW       = 5;
  localparam int RowW       = 3;
  localparam int MaxNibbles = 12;
  localparam int CountW     = $clog2(MaxNibbles + 1);
  localparam int IdxW       = $clog2(MaxNibbles);

  // Request codes
  localparam logic [1:0] CmdInit  = 2'd0;
  localparam logic [1:0] CmdPrint = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  // Display bytes and raw nibbles
  localparam logic [7:0] ByteSetAddr = 8'h80;
  localparam logic [7:0] ByteClear   = 8'h01;
  localparam logic [7:0] ByteFuncSet = 8'h28;
  localparam logic [7:0] ByteDispOn  = 8'h0C;
  localparam logic [7:0] ByteEntry   = 8'h06;
  localparam logic [3:0] NibWake     = 4'h3;
  localparam logic [3:0] NibFourBit  = 4'h2;
  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharNull    = 8'd0;

  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
  } nib_ent_t;

  typedef nib_ent_t [MaxNibbles-1:0] nib_list_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    nib_list_t         ents;
  } job_desc_t;

  typedef struct packed {
    logic              busy;
    logic [CountW-1:0] count;
  } emit_stat_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } cursor_stat_t;

  // DDRAM start address of each panel row.
  function automatic logic [6:0] row_base(input logic [1:0] r);
    logic [6:0] b;
    case (r)
      2'd0:    b = 7'h00;
      2'd1:    b = 7'h40;
      2'd2:    b = 7'h14;
      default: b = 7'h54;
    endcase
    return b;
  endfunction

endpackage

/* sv/lcdcs_ifs.sv */
// Handshake channels: request in, bus nibble out.
interface lcdcs_req_if import lcdcs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_code;

  modport source (output valid, output cmd, output char_code, input ready);
  modport sink (input valid, input cmd, input char_code, output ready);
endinterface

interface lcdcs_nib_if import lcdcs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [3:0] nibble;
  logic       last;

  modport source (output valid, output reg_select, output nibble, output last, input ready);
  modport sink (input valid, input reg_select, input nibble, input last, output ready);
endinterface

/* sv/lcdcs_planner.sv */
// Cursor state and nibble list for one request.
module lcdcs_planner import lcdcs_pkg::*; #(
  parameter int COLUMNS = DefColumns,
  parameter int ROWS    = DefRows
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  logic [1:0]   cmd,
  input  logic [7:0]   char_code,
  output job_desc_t    desc,
  output cursor_stat_t cursor
);

  logic [RowW-1:0] cursor_row, cursor_row_next;
  logic [ColW-1:0] cursor_col, cursor_col_next;

  always_comb begin
    logic            wrap_col, wrap_row, wrapped, send_b, rs_b;
    logic [RowW-1:0] r1, r2, r3;
    logic [ColW-1:0] c1, c2;
    logic [7:0]      byte_a, byte_b;

    desc            = '0;
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;

    // Wrap check on the cursor as left by the previous character.
    wrap_col = cursor_col >= ColW'(COLUMNS);
    c1       = wrap_col ? '0 : cursor_col;
    r1       = wrap_col ? cursor_row + RowW'(1) : cursor_row;
    wrap_row = r1 >= RowW'(ROWS);
    r2       = wrap_row ? '0 : r1;
    c2       = wrap_row ? '0 : c1;
    wrapped  = wrap_col || wrap_row;
    byte_a   = ByteSetAddr | {1'b0, row_base(r2[1:0]) + 7'(c2)};
    r3       = r2 + RowW'(1);

    if (char_code == CharNewline) begin
      send_b = r3 < RowW'(ROWS);
      rs_b   = 1'b0;
      byte_b = ByteSetAddr | {1'b0, row_base(r3[1:0])};
    end else begin
      send_b = 1'b1;
      rs_b   = 1'b1;
      byte_b = char_code;
    end

    unique case (cmd)
      CmdInit: begin
        desc.count    = CountW'(MaxNibbles);
        desc.ents[0]  = '{rs: 1'b0, nib: NibWake};
        desc.ents[1]  = '{rs: 1'b0, nib: NibWake};
        desc.ents[2]  = '{rs: 1'b0, nib: NibWake};
        desc.ents[3]  = '{rs: 1'b0, nib: NibFourBit};
        desc.ents[4]  = '{rs: 1'b0, nib: ByteFuncSet[7:4]};
        desc.ents[5]  = '{rs: 1'b0, nib: ByteFuncSet[3:0]};
        desc.ents[6]  = '{rs: 1'b0, nib: ByteDispOn[7:4]};
        desc.ents[7]  = '{rs: 1'b0, nib: ByteDispOn[3:0]};
        desc.ents[8]  = '{rs: 1'b0, nib: ByteEntry[7:4]};
        desc.ents[9]  = '{rs: 1'b0, nib: ByteEntry[3:0]};
        desc.ents[10] = '{rs: 1'b0, nib: ByteClear[7:4]};
        desc.ents[11] = '{rs: 1'b0, nib: ByteClear[3:0]};
      end
      CmdClear: begin
        desc.count      = CountW'(2);
        desc.ents[0]    = '{rs: 1'b0, nib: ByteClear[7:4]};
        desc.ents[1]    = '{rs: 1'b0, nib: ByteClear[3:0]};
        cursor_row_next = '0;
        cursor_col_next = '0;
      end
      CmdPrint: begin
        if (char_code != CharNull) begin
          if (wrapped) begin
            desc.ents[0] = '{rs: 1'b0, nib: byte_a[7:4]};
            desc.ents[1] = '{rs: 1'b0, nib: byte_a[3:0]};
            desc.ents[2] = '{rs: rs_b, nib: byte_b[7:4]};
            desc.ents[3] = '{rs: rs_b, nib: byte_b[3:0]};
            desc.count   = send_b ? CountW'(4) : CountW'(2);
          end else begin
            desc.ents[0] = '{rs: rs_b, nib: byte_b[7:4]};
            desc.ents[1] = '{rs: rs_b, nib: byte_b[3:0]};
            desc.count   = send_b ? CountW'(2) : CountW'(0);
          end
          if (char_code == CharNewline) begin
            cursor_row_next = r3;
            cursor_col_next = '0;
          end else begin
            cursor_row_next = r2;
            cursor_col_next = c2 + ColW'(1);
          end
        end
      end
      default: begin
        desc.count = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row <= '0;
      cursor_col <= '0;
    end else if (take) begin
      cursor_row <= cursor_row_next;
      cursor_col <= cursor_col_next;
    end
  end

  assign cursor = '{row: cursor_row, col: cursor_col};

endmodule

/* sv/lcdcs_emitter.sv */
// Job register and nibble output register with one-per-cycle drain while nib is ready.
module lcdcs_emitter import lcdcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  job_desc_t  desc,
  output logic       take_ok,
  output emit_stat_t stat,
  lcdcs_nib_if.source nib
);

  logic            job_busy, job_busy_next;
  job_desc_t       job;
  logic [IdxW-1:0] idx;
  logic            out_valid;
  nib_ent_t        out_ent;
  logic            out_last;
  logic            out_free, move, final_move;

  assign out_free   = !out_valid || nib.ready;
  assign move       = job_busy && out_free;
  assign final_move = move && (CountW'(idx) == job.count - CountW'(1));
  assign take_ok    = !job_busy || final_move;

  always_comb begin
    job_busy_next = job_busy && !final_move;
    if (take && (desc.count != '0)) begin
      job_busy_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_busy  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      job_busy <= job_busy_next;
      if (out_free) begin
        out_valid <= move;
      end
    end
  end

  // Hold the job, advance the nibble index, load the output register.
  always_ff @(posedge clk) begin
    if (take) begin
      job <= desc;
      idx <= '0;
    end else if (move) begin
      idx <= idx + IdxW'(1);
    end
    if (move) begin
      out_ent  <= job.ents[idx];
      out_last <= final_move;
    end
  end

  assign nib.valid      = out_valid;
  assign nib.reg_select = out_ent.rs;
  assign nib.nibble     = out_ent.nib;
  assign nib.last       = out_last;
  assign stat           = '{busy: job_busy, count: job.count};

endmodule

/* sv/char_lcd_cursor_sequencer.sv */
// Top level: character display command sequencer for a 4-bit bus.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+----------------------------------
//  req     | in  | valid / ready | cmd[1:0], char_code[7:0]
//  nib     | out | valid / ready | reg_select, nibble[3:0], last
//
// One nibble leaves per cycle while nib is ready; a request produces 0 to 12
// nibbles (a plain character 2, a wrapping one 4), all through the single
// nibble output register. A request that produces no nibble leaves the
// emitter idle. The next request is taken in the cycle the previous job's
// final nibble moves to the output register, so jobs run back to back.
// Reset (rst, synchronous) empties the job and output registers and puts the
// cursor at row 0, column 0. A stall on nib holds the output and the job.
module char_lcd_cursor_sequencer import lcdcs_pkg::*; #(
  parameter int COLUMNS = DefColumns,
  parameter int ROWS    = DefRows
) (
  input logic clk,
  input logic rst,
  lcdcs_req_if.sink   req,
  lcdcs_nib_if.source nib
);

`include "char_lcd_cursor_sequencer_defines.svh"

  logic         take;
  logic         take_ok;
  job_desc_t    desc;
  emit_stat_t   stat;
  cursor_stat_t cursor;

  // Take a request whenever the emitter can hold its job.
  assign req.ready = take_ok;
  assign take      = req.valid && take_ok;

  // Plan the nibble list and advance the cursor on each taken request.
  lcdcs_planner #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_planner (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .cmd       (req.cmd),
    .char_code (req.char_code),
    .desc      (desc),
    .cursor    (cursor)
  );

  // Drain the job one nibble per cycle through the output register while nib is ready.
  lcdcs_emitter u_emitter (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .desc    (desc),
    .take_ok (take_ok),
    .stat    (stat),
    .nib     (nib)
  );

  // The cursor never runs more than one step past the panel edge.
  `LCDCS_ASSERT_SAME(a_cursor_bound, 1'b1, (cursor.col <= ColW'(COLUMNS)) && (cursor.row <= RowW'(ROWS)), "cursor left its range")
  // An idle emitter always takes a request.
  `LCDCS_ASSERT_SAME(a_ready_idle, !stat.busy, req.ready, "idle emitter refused a request")
  // An init request loads a twelve-nibble job.
  `LCDCS_ASSERT_NEXT(a_init_job, take && (req.cmd == CmdInit), stat.busy && (stat.count == CountW'(MaxNibbles)), "init job not loaded")

endmodule
